/* rtl/core/mlcd_pkg.sv */
// Shared constants, types and the microcode table of the pixel plot shadow unit.
package mlcd_pkg;

   // Panel geometry.
   localparam int COLUMNS = 128;
   localparam int ROWS    = 64;
   localparam int PAGES   = (ROWS + 7) / 8;
   localparam int DEPTH   = COLUMNS * PAGES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam logic [7:0] X_MAX = 8'(COLUMNS - 1);
   localparam logic [7:0] Y_MAX = 8'(ROWS - 1);

   // Panel command bytes.
   localparam logic [7:0] CMD_PAGE    = 8'hB0;
   localparam logic [7:0] CMD_COL_HI  = 8'h10;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam logic [3:0] OFFSET_RESET = 4'd1;

   // Request opcodes.
   localparam logic OP_PLOT = 1'b0;
   localparam logic OP_FILL = 1'b1;

   // Microprogram step addresses.
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_READ = 3'd1;
   localparam step_type STEP_MOD  = 3'd2;
   localparam step_type STEP_HI   = 3'd3;
   localparam step_type STEP_DATA = 3'd4;
   localparam step_type STEP_FILL = 3'd5;

   // Which byte an emitting step puts on the bus.
   typedef enum logic [1:0] {
      SEL_PAGE = 2'd0,
      SEL_LO   = 2'd1,
      SEL_HI   = 2'd2,
      SEL_DATA = 2'd3
   } emit_sel_type;

   // How a step picks its successor.
   typedef enum logic [1:0] {
      JMP_SEQ    = 2'd0,
      JMP_GOTO   = 2'd1,
      JMP_ACCEPT = 2'd2,
      JMP_COUNT  = 2'd3
   } jump_type;

   typedef struct packed {
      logic         ready;
      logic         rd;
      logic         wr;
      logic         wr_fill;
      logic         emit;
      emit_sel_type sel;
      logic         last;
      jump_type     jmp;
      step_type     target;
   } uop_type;

   // Control store: one word per step.
   function automatic uop_type uop_rom(input step_type step);
      uop_type u;
      u = '{ready: 1'b0, rd: 1'b0, wr: 1'b0, wr_fill: 1'b0, emit: 1'b0,
            sel: SEL_PAGE, last: 1'b0, jmp: JMP_GOTO, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            u.ready  = 1'b1;
            u.jmp    = JMP_ACCEPT;
            u.target = STEP_READ;
         end
         STEP_READ: begin
            u.rd   = 1'b1;
            u.emit = 1'b1;
            u.sel  = SEL_PAGE;
            u.jmp  = JMP_SEQ;
         end
         STEP_MOD: begin
            u.wr   = 1'b1;
            u.emit = 1'b1;
            u.sel  = SEL_LO;
            u.jmp  = JMP_SEQ;
         end
         STEP_HI: begin
            u.emit = 1'b1;
            u.sel  = SEL_HI;
            u.jmp  = JMP_SEQ;
         end
         STEP_DATA: begin
            u.emit   = 1'b1;
            u.sel    = SEL_DATA;
            u.last   = 1'b1;
            u.jmp    = JMP_GOTO;
            u.target = STEP_IDLE;
         end
         STEP_FILL: begin
            u.wr      = 1'b1;
            u.wr_fill = 1'b1;
            u.jmp     = JMP_COUNT;
            u.target  = STEP_IDLE;
         end
         default: begin
            u.jmp    = JMP_GOTO;
            u.target = STEP_IDLE;
         end
      endcase
      return u;
   endfunction

endpackage

/* rtl/core/mlcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mono_lcd_pixel_plot_shadow_unit.sv */
// Top level of the monochrome LCD pixel plot unit with its display shadow RAM.
//
// Pixel plot front end for a page-organized 128x64 monochrome panel. A plot
// request clamps x to the last column and y to the last row, sets (nonzero
// pixel_value) or clears one bit of the matching shadow byte, and sends four
// words: page command 0xB0+page, low column nibble, 0x10 + high column
// nibble (column = x + csr offset, modulo 256), then the new data byte with
// last set. A fill request loads every shadow byte with pixel_value and
// sends nothing. A plot runs as one dispatch step plus four microcode steps,
// one word each, and a step waits while its word cannot enter the output
// register. A fill writes one shadow byte per cycle through the write port.
// After reset the same sweep clears the shadow RAM to zero, and req_stall
// stays high until the sweep is done. The column offset resets to 1 and
// may be rewritten whenever the unit is idle.
module mono_lcd_pixel_plot_shadow_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_x_coord,
   input  logic [7:0] req_y_coord,
   input  logic [7:0] req_pixel_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_to_command_bus,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);

   import mlcd_pkg::*;

   // Sequencer state.
   step_type          step_ff, step_in;
   uop_type           uop;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [7:0]        fill_ff, fill_in;
   logic [3:0]        offset_ff;

   // Captured plot operands (payload, no reset needed).
   logic [7:0]        x_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [2:0]        bit_ff;
   logic              set_ff;
   logic [7:0]        col_ff;
   logic [7:0]        byte_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_cmd_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              slot_free;
   logic              hold;
   logic              cnt_done;
   logic [7:0]        x_sat;
   logic [7:0]        y_sat;
   logic [ADDR_W-1:0] plot_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        rd_data;
   logic [7:0]        bit_mask;
   logic [7:0]        new_byte;
   logic [7:0]        emit_byte;

   // Decode the current step.
   assign uop       = uop_rom(step_ff);
   assign req_stall = ~uop.ready;
   assign accept    = req_valid & uop.ready;

   // Output register takes a word when empty or when its word leaves now.
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign hold      = uop.emit & ~slot_free;
   assign cnt_done  = (cnt_ff == ADDR_W'(DEPTH - 1));

   // Clamp coordinates at accept.
   assign x_sat = (req_x_coord > X_MAX) ? X_MAX : req_x_coord;
   assign y_sat = (req_y_coord > Y_MAX) ? Y_MAX : req_y_coord;

   // Shadow store is addressed by the raw column, never the offset one.
   assign plot_addr = ADDR_W'(x_ff) * ADDR_W'(PAGES) + ADDR_W'(page_ff);

   // Read-modify-write of one pixel bit.
   assign bit_mask = 8'd1 << bit_ff;
   assign new_byte = set_ff ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

   assign wr_addr = uop.wr_fill ? cnt_ff : plot_addr;
   assign wr_data = uop.wr_fill ? fill_ff : new_byte;

   mlcd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (uop.wr & ~hold),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (uop.rd),
      .rd_addr (plot_addr),
      .rd_data (rd_data)
   );

   // Select the bus byte for this step.
   always_comb begin
      unique case (uop.sel)
         SEL_PAGE: emit_byte = CMD_PAGE + 8'(page_ff);
         SEL_LO:   emit_byte = {4'h0, col_ff[3:0] & NIBBLE_MASK};
         SEL_HI:   emit_byte = CMD_COL_HI + {4'h0, col_ff[7:4] & NIBBLE_MASK};
         SEL_DATA: emit_byte = byte_ff;
         default:  emit_byte = byte_ff;
      endcase
   end

   // Next step, fill pattern and sweep counter.
   always_comb begin
      step_in = step_ff;
      fill_in = fill_ff;
      cnt_in  = cnt_ff;
      if (!hold) begin
         unique case (uop.jmp)
            JMP_SEQ:  step_in = step_ff + STEP_W'(1);
            JMP_GOTO: step_in = uop.target;
            JMP_ACCEPT: begin
               if (accept) begin
                  step_in = (req_op == OP_FILL) ? STEP_FILL : uop.target;
               end
            end
            JMP_COUNT: begin
               if (cnt_done) begin
                  step_in = uop.target;
               end
            end
            default: step_in = STEP_IDLE;
         endcase
      end
      if (uop.wr_fill) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end
      if (accept) begin
         cnt_in = '0;
         if (req_op == OP_FILL) begin
            fill_in = req_pixel_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Start with a sweep that zeroes the shadow store.
         step_ff   <= STEP_FILL;
         fill_ff   <= '0;
         cnt_ff    <= '0;
         offset_ff <= OFFSET_RESET;
      end else begin
         step_ff <= step_in;
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
         if (csr_write_enable) begin
            offset_ff <= csr_write_data;
         end
      end
   end

   // Capture plot operands.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= x_sat;
         page_ff <= PAGE_W'(y_sat[7:3]);
         bit_ff  <= y_sat[2:0];
         set_ff  <= (req_pixel_value != 8'd0);
         col_ff  <= x_sat + {4'h0, offset_ff};
      end
      if (uop.wr && !uop.wr_fill && !hold) begin
         byte_ff <= new_byte;
      end
   end

   // Output register: load a word, drop it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uop.emit && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uop.emit && slot_free) begin
         rsp_cmd_ff  <= (uop.sel != SEL_DATA);
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= uop.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_to_command_bus = rsp_cmd_ff;
   assign rsp_bus_byte       = rsp_byte_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

/* rtl/core/mlcd_checker.sv */
// Port-level checker for the pixel plot shadow unit, bound to the top level.
module mlcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_to_command_bus,
   input logic [7:0] rsp_bus_byte,
   input logic       rsp_last
);

   // The data word, and only it, closes a plot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last != rsp_to_command_bus))
      else $error("last flag does not match data word");

   // No new request while a plot still has words to send.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request taken in the middle of a plot");

   // Clearing sweep holds off requests right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request accepted during clearing sweep");

   // A stalled word stays put.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_bus_byte)
                                    && $stable(rsp_to_command_bus) && $stable(rsp_last)))
      else $error("stalled word changed");

endmodule

bind mono_lcd_pixel_plot_shadow_unit mlcd_checker u_checker (.*);
